### src/satp_pkg.sv
// ----------------------------------------------------------------------------
// satp_pkg
// Shared types, codes and constants of the sprite animation table parser.
// ----------------------------------------------------------------------------
package satp_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_STATES_DEF  = 16;
  localparam int unsigned MAX_FRAMES_DEF  = 16;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // Blob layout
  localparam int unsigned HDR_BYTES     = 8;
  localparam int unsigned PART_BYTES    = 4;
  localparam int unsigned MIN_LEN       = 3;
  localparam int unsigned PART_CNT_BYTE = 6;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // APB register map
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_MAGIC_FIRST  = 1'b0;
  localparam logic        REG_MAGIC_SECOND = 1'b1;

  // Record kinds
  localparam logic REC_FRAME  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_MAGIC0 = 3'd0,
    PH_MAGIC1 = 3'd1,
    PH_COUNT  = 3'd2,
    PH_FCOUNT = 3'd3,
    PH_HEADER = 3'd4,
    PH_PARTS  = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } satp_phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_OVERFLOW  = 3'd5
  } satp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } satp_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [2:0]  status_code;
    logic [3:0]  state_index;
    logic [3:0]  slot_num;
    logic [15:0] frame_offset;
    logic [7:0]  part_count;
    logic [4:0]  drawable_count;
    logic [4:0]  states_found;
    logic        last_of_run;
  } satp_out_t;

  // Which records one transaction produces
  typedef struct packed {
    logic frame_vld;
    logic stat_vld;
  } satp_emit_t;

  function automatic logic [4:0] sat31(input logic [7:0] v);
    sat31 = (v > 8'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

### src/satp_parse.sv
// ----------------------------------------------------------------------------
// satp_parse
// Parser state and its registered update for one blob byte; produces the
// frame record and the status record that the byte may cause.
// ----------------------------------------------------------------------------
module satp_parse #(
  parameter int unsigned MAX_STATES  = satp_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_FRAMES  = satp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned OFFSET_BITS = satp_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  satp_pkg::satp_in_t  in_i,
  input  logic [7:0]          magic_first_i,
  input  logic [7:0]          magic_second_i,
  output satp_pkg::satp_emit_t emit_o,
  output satp_pkg::satp_out_t frame_rec_o,
  output satp_pkg::satp_out_t stat_rec_o
);

  satp_pkg::satp_phase_e  phase_q, phase_d;
  satp_pkg::satp_status_e err_q, err_d, status;
  logic [OFFSET_BITS:0]   pos_q, pos_d;
  logic [OFFSET_BITS-1:0] fstart_q, fstart_d;
  logic [7:0]             decl_q, decl_d;
  logic [7:0]             cur_q, cur_d;
  logic [7:0]             fleft_q, fleft_d;
  logic [7:0]             slot_q, slot_d;
  logic [2:0]             hidx_q, hidx_d;
  logic [9:0]             pbl_q, pbl_d;
  logic [7:0]             fparts_q, fparts_d;
  logic [7:0]             clamp_q, clamp_d;

  logic       pos_ok;
  logic       do_finish;
  logic [7:0] b;
  logic [7:0] nxt_state;
  satp_pkg::satp_phase_e nxt_phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= satp_pkg::PH_MAGIC0;
      err_q    <= satp_pkg::ST_OK;
      pos_q    <= '0;
      fstart_q <= '0;
      decl_q   <= '0;
      cur_q    <= '0;
      fleft_q  <= '0;
      slot_q   <= '0;
      hidx_q   <= '0;
      pbl_q    <= '0;
      fparts_q <= '0;
      clamp_q  <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      err_q    <= err_d;
      pos_q    <= pos_d;
      fstart_q <= fstart_d;
      decl_q   <= decl_d;
      cur_q    <= cur_d;
      fleft_q  <= fleft_d;
      slot_q   <= slot_d;
      hidx_q   <= hidx_d;
      pbl_q    <= pbl_d;
      fparts_q <= fparts_d;
      clamp_q  <= clamp_d;
    end
  end

  assign b         = in_i.data_byte;
  assign pos_ok    = !pos_q[OFFSET_BITS];
  assign nxt_state = cur_q + 8'd1;
  assign nxt_phase = (nxt_state >= decl_q) ? satp_pkg::PH_DONE : satp_pkg::PH_FCOUNT;

  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    pos_d     = pos_q;
    fstart_d  = fstart_q;
    decl_d    = decl_q;
    cur_d     = cur_q;
    fleft_d   = fleft_q;
    slot_d    = slot_q;
    hidx_d    = hidx_q;
    pbl_d     = pbl_q;
    fparts_d  = fparts_q;
    clamp_d   = clamp_q;
    do_finish = 1'b0;
    emit_o    = '0;
    status    = satp_pkg::ST_OK;

    unique case (phase_q)
      satp_pkg::PH_MAGIC0: begin
        if (b != magic_first_i) begin
          err_d   = satp_pkg::ST_BAD_MAGIC;
          phase_d = satp_pkg::PH_ERROR;
        end else begin
          phase_d = satp_pkg::PH_MAGIC1;
        end
      end
      satp_pkg::PH_MAGIC1: begin
        if (b != magic_second_i) begin
          err_d   = satp_pkg::ST_BAD_MAGIC;
          phase_d = satp_pkg::PH_ERROR;
        end else begin
          phase_d = satp_pkg::PH_COUNT;
        end
      end
      satp_pkg::PH_COUNT: begin
        decl_d = b;
        if (b == 8'd0 || b > 8'(MAX_STATES)) begin
          err_d   = satp_pkg::ST_BAD_COUNT;
          phase_d = satp_pkg::PH_ERROR;
        end else begin
          cur_d   = '0;
          phase_d = satp_pkg::PH_FCOUNT;
        end
      end
      satp_pkg::PH_FCOUNT: begin
        fleft_d = b;
        clamp_d = (b > 8'(MAX_FRAMES)) ? 8'(MAX_FRAMES) : b;
        slot_d  = '0;
        if (b == 8'd0) begin
          // state without frames: move straight on
          cur_d   = nxt_state;
          phase_d = nxt_phase;
        end else begin
          phase_d = satp_pkg::PH_HEADER;
          hidx_d  = '0;
        end
      end
      satp_pkg::PH_HEADER: begin
        if (hidx_q == 3'd0 && !pos_ok) begin
          err_d   = satp_pkg::ST_OVERFLOW;
          phase_d = satp_pkg::PH_ERROR;
        end else begin
          if (hidx_q == 3'd0) fstart_d = pos_q[OFFSET_BITS-1:0];
          if (hidx_q == 3'(satp_pkg::PART_CNT_BYTE)) fparts_d = b;
          if (hidx_q == 3'(satp_pkg::HDR_BYTES - 1)) begin
            pbl_d = 10'(fparts_q) * 10'(satp_pkg::PART_BYTES);
            if (fparts_q == 8'd0) do_finish = 1'b1;
            else phase_d = satp_pkg::PH_PARTS;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      satp_pkg::PH_PARTS: begin
        pbl_d = pbl_q - 10'd1;
        if (pbl_d == 10'd0) do_finish = 1'b1;
      end
      satp_pkg::PH_DONE: begin
        // ignore trailing bytes
      end
      satp_pkg::PH_ERROR: begin
        // hold until the final byte
      end
    endcase

    if (do_finish) begin
      emit_o.frame_vld = (slot_q < 8'(MAX_FRAMES));
      if (slot_q != 8'hFF) slot_d = slot_q + 8'd1;
      fleft_d = fleft_q - 8'd1;
      if (fleft_d == 8'd0) begin
        cur_d   = nxt_state;
        phase_d = nxt_phase;
      end else begin
        phase_d = satp_pkg::PH_HEADER;
        hidx_d  = '0;
      end
    end

    if (pos_ok) pos_d = pos_q + (OFFSET_BITS+1)'(1);

    if (pos_q < (OFFSET_BITS+1)'(satp_pkg::MIN_LEN - 1)) status = satp_pkg::ST_SHORT;
    else if (err_d != satp_pkg::ST_OK) status = err_d;
    else if (phase_d != satp_pkg::PH_DONE) status = satp_pkg::ST_TRUNC;
    else status = satp_pkg::ST_OK;

    stat_rec_o                = '0;
    stat_rec_o.record_kind    = satp_pkg::REC_STATUS;
    stat_rec_o.status_code    = status;
    stat_rec_o.states_found   = satp_pkg::sat31(decl_d);
    stat_rec_o.last_of_run    = 1'b1;

    if (in_i.is_final) begin
      emit_o.stat_vld = 1'b1;
      // return to the reset state for the next blob
      phase_d  = satp_pkg::PH_MAGIC0;
      err_d    = satp_pkg::ST_OK;
      pos_d    = '0;
      fstart_d = '0;
      decl_d   = '0;
      cur_d    = '0;
      fleft_d  = '0;
      slot_d   = '0;
      hidx_d   = '0;
      pbl_d    = '0;
      fparts_d = '0;
      clamp_d  = '0;
    end
  end

  always_comb begin
    frame_rec_o                = '0;
    frame_rec_o.record_kind    = satp_pkg::REC_FRAME;
    frame_rec_o.state_index    = cur_q[3:0];
    frame_rec_o.slot_num       = slot_q[3:0];
    frame_rec_o.frame_offset   = 16'(fstart_q);
    frame_rec_o.part_count     = fparts_q;
    frame_rec_o.drawable_count = satp_pkg::sat31(clamp_q);
    frame_rec_o.last_of_run    = !in_i.is_final;
  end

endmodule

### src/sprite_anim_table_parser_core.sv
// ----------------------------------------------------------------------------
// sprite_anim_table_parser_core
// Streaming parser of a sprite animation blob with an APB register port.
// ----------------------------------------------------------------------------
// The blob enters one byte per transaction; the parser takes a new byte in
// every cycle that input stall is low, each byte updating the parser state.
// Its frame and status records go into a four-entry result queue that the
// output channel drains one record per cycle while out_stall_i is low. Input
// stall rises only while that queue holds more than two records, so a byte
// causing two records (the last frame plus the status on the final byte)
// always finds room for both. Magic registers sit at byte addresses 0 and 4;
// the user must write them only while the parser is idle; it is not enforced.
module sprite_anim_table_parser_core #(
  parameter int unsigned MAX_STATES  = satp_pkg::MAX_STATES_DEF,
  parameter int unsigned MAX_FRAMES  = satp_pkg::MAX_FRAMES_DEF,
  parameter int unsigned OFFSET_BITS = satp_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  satp_pkg::satp_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output satp_pkg::satp_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [satp_pkg::PADDR_W-1:0]  paddr,
  input  logic [satp_pkg::PDATA_W-1:0]  pwdata,
  output logic [satp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned QAW = satp_pkg::QAW;

  logic [7:0] magic_first_q, magic_second_q;
  logic       cfg_wr;

  satp_pkg::satp_emit_t emit;
  satp_pkg::satp_out_t  frame_rec, stat_rec;
  logic                 adv, pop;

  satp_pkg::satp_out_t  queue_q [satp_pkg::QDEPTH];
  logic [QAW-1:0]       head_q, tail_q, stat_idx;
  logic [QAW:0]         cnt_q, cnt_d;
  logic [1:0]           n_push;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= '0;
      magic_second_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        satp_pkg::REG_MAGIC_FIRST:  magic_first_q  <= pwdata[7:0];
        satp_pkg::REG_MAGIC_SECOND: magic_second_q <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      satp_pkg::REG_MAGIC_FIRST:  prdata = satp_pkg::PDATA_W'(magic_first_q);
      satp_pkg::REG_MAGIC_SECOND: prdata = satp_pkg::PDATA_W'(magic_second_q);
    endcase
  end

  // Parser
  assign in_stall_o = (cnt_q > (QAW+1)'(satp_pkg::QDEPTH - 2));
  assign adv        = in_valid_i && !in_stall_o;

  satp_parse #(
    .MAX_STATES (MAX_STATES),
    .MAX_FRAMES (MAX_FRAMES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_i          (in_data_i),
    .magic_first_i (magic_first_q),
    .magic_second_i(magic_second_q),
    .emit_o        (emit),
    .frame_rec_o   (frame_rec),
    .stat_rec_o    (stat_rec)
  );

  // Result queue
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = queue_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign n_push      = adv ? (2'(emit.frame_vld) + 2'(emit.stat_vld)) : 2'd0;
  assign stat_idx    = emit.frame_vld ? tail_q + QAW'(1) : tail_q;
  assign cnt_d       = cnt_q + (QAW+1)'(n_push) - (QAW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (pop) head_q <= head_q + QAW'(1);
      tail_q <= tail_q + QAW'(n_push);
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit.frame_vld) queue_q[tail_q]   <= frame_rec;
    if (adv && emit.stat_vld)  queue_q[stat_idx] <= stat_rec;
  end

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(satp_pkg::QDEPTH))
    else $error("result queue overflow");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> (cnt_q <= (QAW+1)'(satp_pkg::QDEPTH - 2)))
    else $error("byte accepted without room for two records");

  a_final_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_data_i.is_final) |=> out_valid_o)
    else $error("final byte produced no status record");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.record_kind == satp_pkg::REC_STATUS)
      |-> out_data_o.last_of_run)
    else $error("status record not marked last");

endmodule
